[rtl/core/amfs_pkg.sv]
// amfs_pkg: shared widths, codes, state and interface types of the allocation map fit search
// unit. Depends on nothing; used by every module of the block but amfs_ram.

package amfs_pkg;

   // field widths
   localparam int MODE_W   = 3;
   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 4;
   localparam int SIZE_W   = 11;
   localparam int ADDR_W   = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // entries that a map index can reach
   localparam int INDEX_DEPTH = 1 << INDEX_W;

   // default map depth
   localparam int MAP_DEPTH_DEFAULT = 1024;

   // reset value of the area size register
   localparam logic [SIZE_W-1:0] AREA_SIZE_RESET = 11'd1024;

   // request modes
   localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FIRST = 3'd1;
   localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WORST = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BEST  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_SIZE  = 1'd1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_RESULT
   } amfs_state_type;

   // per-cycle command to the run unit
   typedef struct packed {
      logic              clear;
      logic              step;
      logic              runs_mode;
      logic              largest;
      logic              elem_free;
      logic [SIZE_W-1:0] elem_idx;
      logic [SIZE_W-1:0] len;
      logic [SIZE_W-1:0] n;
   } amfs_ctl_type;

   // run unit result
   typedef struct packed {
      logic              hit;
      logic [SIZE_W-1:0] off;
   } amfs_sts_type;

endpackage

[rtl/core/allocation_map_fit_search_unit.sv]
// allocation_map_fit_search_unit: top level of the allocation map fit search.
// Depends on amfs_pkg, amfs_ram, amfs_run_unit and amfs_seq.
//
// Keeps a one-bit used/free map of a heap area and answers first, next, worst and
// best fit requests. Requests enter on req_* (valid/stall), one result per request
// leaves on rsp_* (valid/stall). Mode 0 writes one map entry; modes 1 to 4 search.
// The csr_* port sets the area start address and size; write it only while idle.
// A write updates the map entry when the request is accepted. A search scans the map
// one entry per cycle through the single read port of the map memory, up to
// n = min(area_size, MAP_DEPTH) entries; first and next fit stop early on a hit, and a
// next fit that finds nothing past its pointer falls back to a scan from the area start.
// One request at a time: req_stall is high from accept until the result is handed to
// the output register. The output register holds the result while rsp_stall is high,
// and the next request is already taken meanwhile.
// Reset: the map memory is swept to all free, one entry per cycle over all
// min(MAP_DEPTH, 1024) entries; req_stall stays high during the sweep. Configuration
// writes are taken at any time.

module allocation_map_fit_search_unit #(
   parameter int MAP_DEPTH = amfs_pkg::MAP_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [amfs_pkg::MODE_W-1:0]       req_mode,
   input  logic [amfs_pkg::INDEX_W-1:0]      req_map_index,
   input  logic [amfs_pkg::VALUE_W-1:0]      req_entry_value,
   input  logic [amfs_pkg::SIZE_W-1:0]       req_request_size,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [amfs_pkg::ADDR_W-1:0]       rsp_block_address,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [amfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [amfs_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int RAM_DEPTH = (MAP_DEPTH < amfs_pkg::INDEX_DEPTH) ?
                              MAP_DEPTH : amfs_pkg::INDEX_DEPTH;
   localparam int RAM_AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   logic [amfs_pkg::ADDR_W-1:0]  area_start_ff, area_start_in;
   logic [amfs_pkg::SIZE_W-1:0]  area_size_ff, area_size_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [amfs_pkg::ADDR_W-1:0]  rsp_block_address_ff, rsp_block_address_in;

   logic [amfs_pkg::SIZE_W-1:0]  n;
   logic                         out_free;
   logic                         res_load;
   logic                         ram_we;
   logic [RAM_AW-1:0]            ram_waddr;
   logic                         ram_wdata;
   logic                         ram_re;
   logic [RAM_AW-1:0]            ram_raddr;
   logic                         ram_rdata;
   amfs_pkg::amfs_ctl_type       ctl;
   amfs_pkg::amfs_sts_type       sts;

   // configuration registers
   always_comb begin
      area_start_in = area_start_ff;
      area_size_in  = area_size_ff;
      if (csr_write_enable) begin
         case (csr_index)
            amfs_pkg::CSR_AREA_START: area_start_in = csr_write_data;
            amfs_pkg::CSR_AREA_SIZE:  area_size_in  = csr_write_data[amfs_pkg::SIZE_W-1:0];
            default: begin
               area_start_in = area_start_ff;
            end
         endcase
      end
   end

   // live entry count, clipped to the map depth
   always_comb begin
      if (32'(area_size_ff) > 32'(MAP_DEPTH)) begin
         n = amfs_pkg::SIZE_W'(MAP_DEPTH);
      end else begin
         n = area_size_ff;
      end
   end

   // output register
   always_comb begin
      out_free             = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_found_in         = rsp_found_ff;
      rsp_block_address_in = rsp_block_address_ff;
      if (res_load) begin
         rsp_valid_in         = 1'b1;
         rsp_found_in         = sts.hit;
         rsp_block_address_in = sts.hit ?
            (area_start_ff + {{(amfs_pkg::ADDR_W-amfs_pkg::SIZE_W){1'b0}}, sts.off}) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_start_ff <= '0;
         area_size_ff  <= amfs_pkg::AREA_SIZE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         area_start_ff <= area_start_in;
         area_size_ff  <= area_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff         <= rsp_found_in;
      rsp_block_address_ff <= rsp_block_address_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_block_address = rsp_block_address_ff;

   // used/free map
   amfs_ram #(
      .WIDTH (1),
      .DEPTH (RAM_DEPTH)
   ) u_map (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_enable  (ram_re),
      .read_addr    (ram_raddr),
      .read_data    (ram_rdata)
   );

   // sequencer
   amfs_seq #(
      .MAP_DEPTH (MAP_DEPTH)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_map_index    (req_map_index),
      .req_entry_value  (req_entry_value),
      .req_request_size (req_request_size),
      .n                (n),
      .out_free         (out_free),
      .res_load         (res_load),
      .ram_we           (ram_we),
      .ram_waddr        (ram_waddr),
      .ram_wdata        (ram_wdata),
      .ram_re           (ram_re),
      .ram_raddr        (ram_raddr),
      .ram_rdata        (ram_rdata),
      .ctl              (ctl),
      .sts              (sts)
   );

   // shared run tracker
   amfs_run_unit u_run (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts)
   );

endmodule

[rtl/core/amfs_ram.sv]
// amfs_ram: generic single write port RAM with one registered read port.
// Depends on nothing.

module amfs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                      write_data,
   input  logic                                  read_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                      read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

[rtl/core/amfs_run_unit.sv]
// amfs_run_unit: shared run tracker, consumes one map entry per step and keeps the
// current free run, the best candidate and the hit. Depends on amfs_pkg.

module amfs_run_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  amfs_pkg::amfs_ctl_type ctl,
   output amfs_pkg::amfs_sts_type sts
);

   logic [amfs_pkg::SIZE_W-1:0] run_ff, run_in;
   logic [amfs_pkg::SIZE_W-1:0] start_ff, start_in;
   logic [amfs_pkg::SIZE_W-1:0] pick_ff, pick_in;
   logic [amfs_pkg::SIZE_W-1:0] off_ff, off_in;
   logic                        hit_ff, hit_in;
   logic [amfs_pkg::SIZE_W:0]   run_inc;
   logic                        better;

   // one add and compare per entry
   always_comb begin
      run_inc = {1'b0, run_ff} + {{amfs_pkg::SIZE_W{1'b0}}, 1'b1};
      better  = ctl.largest ? (run_ff >= pick_ff) : (run_ff <= pick_ff);
   end

   // run tracking
   always_comb begin
      run_in   = run_ff;
      start_in = start_ff;
      pick_in  = pick_ff;
      off_in   = off_ff;
      hit_in   = hit_ff;
      if (ctl.clear) begin
         run_in  = '0;
         hit_in  = 1'b0;
         pick_in = ctl.largest ? '0 : ctl.n;
      end else if (ctl.step) begin
         if (!ctl.runs_mode) begin
            // first or next fit: stop at the first run long enough
            if (!hit_ff) begin
               if (ctl.elem_free) begin
                  run_in = run_inc[amfs_pkg::SIZE_W-1:0];
                  if (run_inc >= {1'b0, ctl.len}) begin
                     hit_in = 1'b1;
                     off_in = ctl.elem_idx - run_ff;
                  end
               end else begin
                  run_in = '0;
               end
            end
         end else begin
            // worst or best fit: judge each maximal run at its end
            if (ctl.elem_free) begin
               if (run_ff == '0) begin
                  start_in = ctl.elem_idx;
               end
               run_in = run_inc[amfs_pkg::SIZE_W-1:0];
            end else begin
               if ((run_ff != '0) && (run_ff >= ctl.len) && better) begin
                  pick_in = run_ff;
                  off_in  = start_ff;
                  hit_in  = 1'b1;
               end
               run_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff   <= run_in;
      start_ff <= start_in;
      pick_ff  <= pick_in;
      off_ff   <= off_in;
   end

   assign sts.hit = hit_ff;
   assign sts.off = off_ff;

endmodule

[rtl/core/amfs_seq.sv]
// amfs_seq: sequencer of the fit search; clearing pass, request intake, map scan
// addressing, next-fit pointer and fallback. Depends on amfs_pkg.

module amfs_seq #(
   parameter int MAP_DEPTH = amfs_pkg::MAP_DEPTH_DEFAULT,
   localparam int RAM_DEPTH = (MAP_DEPTH < amfs_pkg::INDEX_DEPTH) ?
                              MAP_DEPTH : amfs_pkg::INDEX_DEPTH,
   localparam int RAM_AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [amfs_pkg::MODE_W-1:0]   req_mode,
   input  logic [amfs_pkg::INDEX_W-1:0]  req_map_index,
   input  logic [amfs_pkg::VALUE_W-1:0]  req_entry_value,
   input  logic [amfs_pkg::SIZE_W-1:0]   req_request_size,
   // live area size and result handoff
   input  logic [amfs_pkg::SIZE_W-1:0]   n,
   input  logic                          out_free,
   output logic                          res_load,
   // map memory
   output logic                          ram_we,
   output logic [RAM_AW-1:0]             ram_waddr,
   output logic                          ram_wdata,
   output logic                          ram_re,
   output logic [RAM_AW-1:0]             ram_raddr,
   input  logic                          ram_rdata,
   // run unit
   output amfs_pkg::amfs_ctl_type        ctl,
   input  amfs_pkg::amfs_sts_type        sts
);

   localparam logic [amfs_pkg::SIZE_W-1:0] RAM_DEPTH_S = amfs_pkg::SIZE_W'(RAM_DEPTH);
   localparam logic [amfs_pkg::SIZE_W-1:0] RAM_LAST    = amfs_pkg::SIZE_W'(RAM_DEPTH - 1);
   localparam logic [amfs_pkg::SIZE_W-1:0] CNT_ONE     = amfs_pkg::SIZE_W'(1);

   amfs_pkg::amfs_state_type      state_ff, state_in;
   logic [amfs_pkg::SIZE_W-1:0]   cnt_ff, cnt_in;
   logic                          issued_ff, issued_in;
   logic                          pv_ff, pv_in;
   logic [amfs_pkg::SIZE_W-1:0]   pidx_ff, pidx_in;
   logic [amfs_pkg::SIZE_W-1:0]   nf_ff, nf_in;
   logic                          fallback_ff, fallback_in;
   logic [amfs_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [amfs_pkg::SIZE_W-1:0]   len_ff, len_in;

   logic                          req_search;
   logic [amfs_pkg::SIZE_W-1:0]   start_ofs;
   logic                          issue;
   logic                          last_proc;
   logic                          first_kind;
   logic                          restart;
   logic                          next_hit;
   logic [amfs_pkg::MODE_W-1:0]   kind_mode;

   // decode
   always_comb begin
      req_search = (req_mode == amfs_pkg::MODE_FIRST) || (req_mode == amfs_pkg::MODE_NEXT) ||
                   (req_mode == amfs_pkg::MODE_WORST) || (req_mode == amfs_pkg::MODE_BEST);
      start_ofs  = (req_mode == amfs_pkg::MODE_NEXT) ? nf_ff : '0;
      first_kind = (mode_ff == amfs_pkg::MODE_FIRST) || (mode_ff == amfs_pkg::MODE_NEXT);
      issue      = (state_ff == amfs_pkg::ST_SCAN) && !issued_ff;
      last_proc  = (state_ff == amfs_pkg::ST_SCAN) && pv_ff && (pidx_ff == n);
      restart    = (state_ff == amfs_pkg::ST_EVAL) && (mode_ff == amfs_pkg::MODE_NEXT) &&
                   !fallback_ff && !sts.hit;
      next_hit   = (state_ff == amfs_pkg::ST_EVAL) && (mode_ff == amfs_pkg::MODE_NEXT) &&
                   !fallback_ff && sts.hit;
      kind_mode  = (state_ff == amfs_pkg::ST_IDLE) ? req_mode : mode_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         amfs_pkg::ST_CLEAR: begin
            if (cnt_ff == RAM_LAST) begin
               state_in = amfs_pkg::ST_IDLE;
            end
         end
         amfs_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (!req_search) begin
                  state_in = amfs_pkg::ST_RESULT;
               end else if (start_ofs > n) begin
                  state_in = amfs_pkg::ST_EVAL;
               end else begin
                  state_in = amfs_pkg::ST_SCAN;
               end
            end
         end
         amfs_pkg::ST_SCAN: begin
            if (last_proc || (first_kind && sts.hit)) begin
               state_in = amfs_pkg::ST_EVAL;
            end
         end
         amfs_pkg::ST_EVAL: begin
            state_in = restart ? amfs_pkg::ST_SCAN : amfs_pkg::ST_RESULT;
         end
         amfs_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = amfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = amfs_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = 1'b1;
      res_load      = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = cnt_ff[RAM_AW-1:0];
      ram_wdata     = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = cnt_ff[RAM_AW-1:0];
      ctl.clear     = 1'b0;
      ctl.step      = 1'b0;
      ctl.runs_mode = (kind_mode == amfs_pkg::MODE_WORST) || (kind_mode == amfs_pkg::MODE_BEST);
      ctl.largest   = (kind_mode == amfs_pkg::MODE_WORST);
      ctl.elem_free = (pidx_ff < n) && ((pidx_ff >= RAM_DEPTH_S) || !ram_rdata);
      ctl.elem_idx  = pidx_ff;
      ctl.len       = len_ff;
      ctl.n         = n;
      case (state_ff)
         amfs_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
         end
         amfs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ctl.clear = req_valid;
            if (req_valid && (req_mode == amfs_pkg::MODE_WRITE) &&
                (amfs_pkg::SIZE_W'(req_map_index) < RAM_DEPTH_S)) begin
               ram_we    = 1'b1;
               ram_waddr = req_map_index[RAM_AW-1:0];
               ram_wdata = (req_entry_value != '0);
            end
         end
         amfs_pkg::ST_SCAN: begin
            ram_re   = issue && (cnt_ff < RAM_DEPTH_S);
            ctl.step = pv_ff;
         end
         amfs_pkg::ST_EVAL: begin
            ctl.clear = restart;
         end
         amfs_pkg::ST_RESULT: begin
            res_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // counters, pointer and latched request
   always_comb begin
      cnt_in      = cnt_ff;
      issued_in   = issued_ff;
      pv_in       = issue;
      pidx_in     = cnt_ff;
      nf_in       = nf_ff;
      fallback_in = fallback_ff;
      mode_in     = mode_ff;
      len_in      = len_ff;
      if (state_ff == amfs_pkg::ST_CLEAR) begin
         cnt_in = cnt_ff + CNT_ONE;
      end
      if ((state_ff == amfs_pkg::ST_IDLE) && req_valid) begin
         mode_in     = req_mode;
         len_in      = req_request_size;
         cnt_in      = start_ofs;
         issued_in   = 1'b0;
         fallback_in = 1'b0;
      end
      if (issue) begin
         cnt_in = cnt_ff + CNT_ONE;
         if (cnt_ff == n) begin
            issued_in = 1'b1;
         end
      end
      // next fit found nothing past the pointer: rescan from the area start
      if (restart) begin
         cnt_in      = '0;
         issued_in   = 1'b0;
         fallback_in = 1'b1;
      end
      if (next_hit) begin
         nf_in = sts.off + len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= amfs_pkg::ST_CLEAR;
         cnt_ff      <= '0;
         issued_ff   <= 1'b1;
         pv_ff       <= 1'b0;
         nf_ff       <= '0;
         fallback_ff <= 1'b0;
         mode_ff     <= amfs_pkg::MODE_WRITE;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         issued_ff   <= issued_in;
         pv_ff       <= pv_in;
         nf_ff       <= nf_in;
         fallback_ff <= fallback_in;
         mode_ff     <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      len_ff  <= len_in;
   end

   // the next-fit pointer moves only when a next-fit pass is judged
   a_nf_only_in_eval: assert property (@(posedge clock) disable iff (reset)
      (nf_ff != $past(nf_ff)) |-> ($past(state_ff) == amfs_pkg::ST_EVAL))
      else $error("next-fit pointer changed outside evaluation");

   // read data in flight only during a scan or its evaluation
   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> ((state_ff == amfs_pkg::ST_SCAN) || (state_ff == amfs_pkg::ST_EVAL)))
      else $error("map read pending outside a scan");

   // an accepted request always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != amfs_pkg::ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

endmodule
